[rtl/core/clnr_pkg.sv]
`default_nettype none

package clnr_pkg;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned STORE_DEPTH = 64;
   localparam int unsigned STORE_AW    = 6;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] FRAMES_RESET = 8'd50;

   localparam logic [6:0] CYCLE_STEPS = 7'd68;
   localparam logic [6:0] ROW1_DATA   = 7'd2;
   localparam logic [6:0] CMD2_STEP   = 7'd34;
   localparam logic [6:0] ROW2_DATA   = 7'd36;

   localparam logic [3:0] CMD1_HI = 4'h8;
   localparam logic [3:0] CMD1_LO = 4'h0;
   localparam logic [3:0] CMD2_HI = 4'hA;
   localparam logic [3:0] CMD2_LO = 4'h8;

   localparam logic [7:0] ROW_MAX = 8'd3;
   localparam logic [7:0] COL_MAX = 8'd15;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] row;
      logic [7:0] start_col;
      logic [7:0] char_offset;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [3:0] nibble;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/clnr_ram.sv]
`default_nettype none

module clnr_ram import clnr_pkg::*; #(
   parameter int unsigned WIDTH = CHAR_W,
   parameter int unsigned DEPTH = STORE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/char_lcd_nibble_refresh.sv]
// char_lcd_nibble_refresh
// Shadows a 4x16 character store and streams it to a 16x2 character LCD as
// 4-bit nibbles, one nibble per refresh tick.
// Request channel: a request is taken at a rising edge with start high and
// busy low. busy is only high while reset is held, so a request can be taken
// every cycle. Opcode tick produces one nibble, write stores one character,
// clear fills the store with spaces; write and clear produce nothing.
// Result channel: rsp_strobe marks rsp_data for the one cycle right after the
// tick request edge; the result comes through the store read register.
// The receiver cannot stall; throughput is one request per cycle.
// CSR channel: csr_ready is always high; csr_data sets frames_per_half; the
// user must write it only while no tick result is pending (not enforced).
// Reset (synchronous): store reads back as spaces, step, frame count and the
// displayed half go to zero, frames_per_half returns to 50.
// The store is a 64x8 RAM with one registered read port; a valid bit per
// entry gives the space value for entries never written since reset/clear.
`default_nettype none

module char_lcd_nibble_refresh import clnr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_strobe,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data
);

   logic       accept;
   logic       tick;
   logic       wr_en;
   logic       clr;

   logic [7:0] frames_ff;
   logic [6:0] step_ff;
   logic [6:0] step_in;
   logic [7:0] cycle_ff;
   logic [7:0] cycle_in;
   logic       half_ff;
   logic       half_in;

   logic [6:0] step_cur;
   logic       second_row;
   logic [6:0] pos;
   logic       is_data;
   logic [3:0] ctrl_nib;
   logic [7:0] cycle_inc;

   logic [1:0] row_c;
   logic [3:0] col_c;
   logic [8:0] col_sum;
   logic [STORE_AW-1:0] wr_addr;
   logic [STORE_AW-1:0] rd_addr;

   logic [STORE_DEPTH-1:0] valid_ff;
   logic [CHAR_W-1:0]      rd_data;
   logic [CHAR_W-1:0]      ch;

   logic       rsp_strobe_ff;
   logic       is_data_ff;
   logic       lo_sel_ff;
   logic [3:0] ctrl_nib_ff;
   logic       valid_rd_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   assign accept = start & ~busy;
   assign tick   = accept & (req_data.opcode == OP_TICK);
   assign clr    = accept & (req_data.opcode == OP_CLEAR);

   // write address with clamping; past the last column the write is dropped
   always_comb begin
      row_c   = (req_data.row > ROW_MAX) ? ROW_MAX[1:0] : req_data.row[1:0];
      col_c   = (req_data.start_col > COL_MAX) ? COL_MAX[3:0] : req_data.start_col[3:0];
      col_sum = {5'd0, col_c} + {1'b0, req_data.char_offset};
      wr_addr = {row_c, col_sum[3:0]};
      wr_en   = accept && (req_data.opcode == OP_WRITE) && (col_sum <= {1'b0, COL_MAX});
   end

   // step decode
   always_comb begin
      step_cur   = (step_ff >= CYCLE_STEPS) ? 7'd0 : step_ff;
      second_row = step_cur >= ROW2_DATA;
      pos        = second_row ? (step_cur - ROW2_DATA) : (step_cur - ROW1_DATA);
      is_data    = second_row || ((step_cur >= ROW1_DATA) && (step_cur < CMD2_STEP));
      case (step_cur)
         7'd0:                   ctrl_nib = CMD1_HI;
         7'd1:                   ctrl_nib = CMD1_LO;
         CMD2_STEP:              ctrl_nib = CMD2_HI;
         CMD2_STEP + 7'd1:       ctrl_nib = CMD2_LO;
         default:                ctrl_nib = 4'h0;
      endcase
      rd_addr = {half_ff, second_row, pos[4:1]};
   end

   // step, frame count and half for the next tick
   always_comb begin
      step_in   = step_cur + 7'd1;
      cycle_in  = cycle_ff;
      half_in   = half_ff;
      cycle_inc = cycle_ff + 8'd1;
      if (step_in >= CYCLE_STEPS) begin
         step_in = 7'd0;
         if (cycle_inc == frames_ff) begin
            cycle_in = 8'd0;
            half_in  = ~half_ff;
         end else begin
            cycle_in = cycle_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else if (csr_valid && csr_ready) begin
         frames_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 7'd0;
         cycle_ff <= 8'd0;
         half_ff  <= 1'b0;
      end else if (tick) begin
         step_ff  <= step_in;
         cycle_ff <= cycle_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   clnr_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.char_code),
      .rd_en   (tick),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tick;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         is_data_ff  <= is_data;
         lo_sel_ff   <= pos[0];
         ctrl_nib_ff <= ctrl_nib;
         valid_rd_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      ch = valid_rd_ff ? rd_data : SPACE_CODE;
      rsp_data.is_data = is_data_ff;
      if (is_data_ff) begin
         rsp_data.nibble = lo_sel_ff ? ch[3:0] : ch[7:4];
      end else begin
         rsp_data.nibble = ctrl_nib_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;

endmodule

`default_nettype wire

[rtl/core/clnr_checker.sv]
`default_nettype none

module clnr_checker import clnr_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   logic tick_req;
   assign tick_req = start && !busy && (req_data.opcode == OP_TICK);

   // every tick request gives one result on the next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      tick_req |=> rsp_strobe)
      else $error("tick request without result");

   // no result without a tick request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !tick_req |=> !rsp_strobe)
      else $error("result without tick request");

   // control nibbles only come from the two set-cursor commands
   a_ctrl_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_data) |->
         (rsp_data.nibble == CMD1_HI || rsp_data.nibble == CMD1_LO ||
          rsp_data.nibble == CMD2_HI))
      else $error("unexpected control nibble");

   // first tick after reset starts the refresh cycle
   a_first_cmd: assert property (@(posedge clock) disable iff (reset)
      ($fell(reset) && tick_req) |=>
         (rsp_strobe && !rsp_data.is_data && rsp_data.nibble == CMD1_HI))
      else $error("refresh does not restart after reset");

endmodule

bind char_lcd_nibble_refresh clnr_checker u_clnr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

[dv/char_lcd_nibble_refresh_tb.sv]
`timescale 1ns / 1ps

module char_lcd_nibble_refresh_tb;
   import clnr_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASE_ITEMS = 238;
   localparam int unsigned NUM_PHASES = 6;
   localparam int unsigned NUM_DIRECTED = 21;

   typedef struct packed {
      req_type    req;
      logic       pinned;
      rsp_type    want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   // shadow of the display state
   logic [7:0]  lcd_store [STORE_DEPTH];
   logic [6:0]  refresh_step;
   logic [7:0]  frame_count;
   logic        shown_half;
   logic [7:0]  frames_per_half_cfg;

   rsp_type     pending_nibbles [$];
   int unsigned mismatch_count;
   int unsigned cycles_run;

   char_lcd_nibble_refresh u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic apply_request(input req_type r, output bit has_nib, output rsp_type nib);
      logic [7:0] row_c;
      logic [7:0] col_c;
      logic [8:0] col_sum;
      logic [6:0] pos;
      logic [7:0] ch;
      has_nib = 1'b0;
      nib = '0;
      case (r.opcode)
         OP_WRITE: begin
            row_c = (r.row > ROW_MAX) ? ROW_MAX : r.row;
            col_c = (r.start_col > COL_MAX) ? COL_MAX : r.start_col;
            col_sum = {1'b0, col_c} + {1'b0, r.char_offset};
            // a character running past the last column is dropped
            if (col_sum <= {1'b0, COL_MAX})
               lcd_store[{row_c[1:0], col_sum[3:0]}] = r.char_code;
         end
         OP_CLEAR: begin
            for (int k = 0; k < STORE_DEPTH; k++)
               lcd_store[k] = SPACE_CODE;
         end
         OP_TICK: begin
            has_nib = 1'b1;
            if (refresh_step == 7'd0) begin
               nib.nibble = CMD1_HI;
            end else if (refresh_step == 7'd1) begin
               nib.nibble = CMD1_LO;
            end else if (refresh_step < CMD2_STEP) begin
               pos = refresh_step - ROW1_DATA;
               ch = lcd_store[{shown_half, 1'b0, pos[4:1]}];
               nib.is_data = 1'b1;
               nib.nibble = pos[0] ? ch[3:0] : ch[7:4];
            end else if (refresh_step == CMD2_STEP) begin
               nib.nibble = CMD2_HI;
            end else if (refresh_step == CMD2_STEP + 7'd1) begin
               nib.nibble = CMD2_LO;
            end else begin
               pos = refresh_step - ROW2_DATA;
               ch = lcd_store[{shown_half, 1'b1, pos[4:1]}];
               nib.is_data = 1'b1;
               nib.nibble = pos[0] ? ch[3:0] : ch[7:4];
            end
            if (refresh_step == CYCLE_STEPS - 7'd1) begin
               refresh_step = 7'd0;
               frame_count = frame_count + 8'd1;
               // counter only clears on an exact match, so a lowered limit wraps through 255
               if (frame_count == frames_per_half_cfg) begin
                  shown_half = ~shown_half;
                  frame_count = 8'd0;
               end
            end else begin
               refresh_step = refresh_step + 7'd1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input req_type r, input int unsigned gap, input logic pinned,
                               input rsp_type want);
      bit      has_nib;
      rsp_type nib;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_request(r, has_nib, nib);
      if (has_nib)
         pending_nibbles.push_back(pinned ? want : nib);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_nibbles.size() != 0) @(posedge clock);
      // a trailing write may still be in flight with nothing to wait on
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_nibbles
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_nibbles.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected nibble: is_data=%0d nibble=%h", rsp_data.is_data,
                        rsp_data.nibble);
            mismatch_count++;
         end else begin
            want = pending_nibbles.pop_front();
            if (rsp_data.is_data !== want.is_data || rsp_data.nibble !== want.nibble) begin
               if (mismatch_count < 10)
                  $display("nibble mismatch: exp is_data=%0d nibble=%h, got %0d %h",
                           want.is_data, want.nibble, rsp_data.is_data, rsp_data.nibble);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_tab [NUM_DIRECTED];
      logic [7:0]  phase_frames [NUM_PHASES];
      req_type     r;
      int unsigned sent;
      int unsigned pick;
      int unsigned gap;
      bit          burst;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 8'd0;
      mismatch_count = 0;
      cycles_run = 0;

      for (int k = 0; k < STORE_DEPTH; k++)
         lcd_store[k] = SPACE_CODE;
      refresh_step = 7'd0;
      frame_count = 8'd0;
      shown_half = 1'b0;
      frames_per_half_cfg = FRAMES_RESET;

      dir_tab = '{
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{1'b0, CMD1_HI}},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{1'b0, CMD1_LO}},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{1'b1, 4'h2}},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{1'b1, 4'h0}},
         '{'{OP_WRITE,  8'd0,   8'd2,   8'd0,   8'hFF}, 1'b0, '0},
         // row and column both clamp to the last cell
         '{'{OP_WRITE,  8'd255, 8'd255, 8'd0,   8'h00}, 1'b0, '0},
         '{'{OP_WRITE,  8'd0,   8'd15,  8'd1,   8'hAB}, 1'b0, '0},
         '{'{OP_WRITE,  8'd1,   8'd0,   8'd255, 8'h55}, 1'b0, '0},
         '{'{OP_WRITE,  8'd0,   8'd0,   8'd15,  8'h5A}, 1'b0, '0},
         '{'{OP_WRITE,  8'd2,   8'd7,   8'd8,   8'hC3}, 1'b0, '0},
         '{'{OP_UNUSED, 8'hFF,  8'hFF,  8'hFF,  8'hFF}, 1'b0, '0},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{1'b1, 4'h2}},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{1'b1, 4'h0}},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0},
         '{'{OP_CLEAR,  8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0},
         // write to a cell that the second tick after it reads
         '{'{OP_WRITE,  8'd0,   8'd4,   8'd0,   8'h81}, 1'b0, '0},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0},
         '{'{OP_TICK,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, '0}
      };

      phase_frames[0] = 8'd1;
      phase_frames[1] = 8'd255;
      phase_frames[2] = 8'd2;
      phase_frames[3] = 8'd3;
      phase_frames[4] = 8'($urandom_range(1, 255));
      phase_frames[5] = 8'd1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(dir_tab[i].req, (i % 3 == 2) ? 2 : 0, dir_tab[i].pinned, dir_tab[i].want);

      burst = 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_data <= phase_frames[p];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         frames_per_half_cfg = phase_frames[p];
         @(negedge clock);
         csr_valid <= 1'b0;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (sent % 32 == 0)
               burst = ($urandom_range(0, 3) == 0);
            r.row = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                                : 8'($urandom_range(0, 255));
            r.start_col = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                      : 8'($urandom_range(0, 255));
            r.char_offset = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15))
                                                       : 8'($urandom_range(0, 255));
            r.char_code = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 60)
               r.opcode = OP_TICK;
            else if (pick < 93)
               r.opcode = OP_WRITE;
            else if (pick < 96)
               r.opcode = OP_CLEAR;
            else
               r.opcode = OP_UNUSED;
            gap = burst ? 0 : $urandom_range(0, 7);
            send_request(r, gap, 1'b0, '0);
            if (r.opcode != OP_UNUSED)
               sent++;
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
